[rtl/obm_pkg.sv]
`default_nettype none
package obm_pkg;

  typedef enum logic [1:0] {
    OUT_ADDED  = 2'd0,
    OUT_TRADE  = 2'd1,
    OUT_REJECT = 2'd2
  } outcome_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_empty;
  } ctrl_stat_t;

  typedef struct packed {
    logic rotate;
    logic drop;
    logic append;
  } book_cmd_t;

endpackage
`default_nettype wire

[rtl/obm_book.sv]
`default_nettype none
module obm_book #(
  parameter int BOOK_DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  obm_pkg::book_cmd_t                   cmd,
  input  wire [15:0]                           wr_id,
  input  wire [15:0]                           wr_price,
  output logic [15:0]                          head_id,
  output logic [15:0]                          head_price,
  output logic [$clog2(BOOK_DEPTH + 1) - 1:0]  count,
  output logic                                 full
);
  import obm_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH + 1);

  logic [15:0] ids    [BOOK_DEPTH];
  logic [15:0] prices [BOOK_DEPTH];
  logic [CW-1:0] tail;

  assign tail       = count - CW'(1);
  assign head_id    = ids[0];
  assign head_price = prices[0];
  assign full       = (count == CW'(BOOK_DEPTH));

  // rotate: head goes to the tail, the rest move up; drop: head leaves
  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.append && (CW'(i) == count)) begin
        ids[i]    <= wr_id;
        prices[i] <= wr_price;
      end else if (cmd.rotate && (CW'(i) == tail)) begin
        ids[i]    <= ids[0];
        prices[i] <= prices[0];
      end else if (cmd.rotate || cmd.drop) begin
        if (i < BOOK_DEPTH - 1) begin
          ids[i]    <= ids[(i + 1) % BOOK_DEPTH];
          prices[i] <= prices[(i + 1) % BOOK_DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end else if (cmd.drop) begin
      count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

[rtl/obm_ctrl.sv]
`default_nettype none
module obm_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  obm_pkg::ctrl_stat_t stat,
  output obm_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import obm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_empty) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SCAN: begin
        busy       = 1'b1;
        cmd.step   = !stat.scan_empty;
        cmd.finish = stat.scan_empty;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/obm_datapath.sv]
`default_nettype none
module obm_datapath #(
  parameter int BOOK_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  obm_pkg::ctrl_cmd_t  cmd,
  output obm_pkg::ctrl_stat_t stat,
  input  wire [15:0]          order_id,
  input  wire [15:0]          order_price,
  input  wire                 is_buy,
  output logic                done,
  output logic [1:0]          outcome,
  output logic [15:0]         counter_id,
  output logic [15:0]         trade_price,
  output logic [4:0]          buy_level,
  output logic [4:0]          sell_level
);
  import obm_pkg::*;

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  logic [15:0]   ord_id;
  logic [15:0]   ord_price;
  logic          ord_buy;
  logic [CW-1:0] remaining;
  logic          matched;
  logic [15:0]   m_id;
  logic [15:0]   m_price;
  outcome_t      res_outcome;

  book_cmd_t     buy_cmd, sell_cmd;
  logic [15:0]   buy_head_id, buy_head_price, sell_head_id, sell_head_price;
  logic [CW-1:0] buy_cnt, sell_cnt;
  logic          buy_full, sell_full;

  logic [15:0]   opp_id, opp_price;
  logic          qual, hit, app_buy, app_sell;
  logic [CW-1:0] buy_after, sell_after;
  logic [LW-1:0] buy_ext, sell_ext;

  obm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_buy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (buy_cmd),
    .wr_id     (ord_id),
    .wr_price  (ord_price),
    .head_id   (buy_head_id),
    .head_price(buy_head_price),
    .count     (buy_cnt),
    .full      (buy_full)
  );

  obm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_sell (
    .clk       (clk),
    .rst       (rst),
    .cmd       (sell_cmd),
    .wr_id     (ord_id),
    .wr_price  (ord_price),
    .head_id   (sell_head_id),
    .head_price(sell_head_price),
    .count     (sell_cnt),
    .full      (sell_full)
  );

  assign stat.scan_empty = (remaining == '0);

  assign opp_id    = ord_buy ? sell_head_id : buy_head_id;
  assign opp_price = ord_buy ? sell_head_price : buy_head_price;
  assign qual      = ord_buy ? (opp_price <= ord_price) : (opp_price >= ord_price);
  assign hit       = !matched && qual;

  assign app_buy  = cmd.finish && !matched && ord_buy && !buy_full;
  assign app_sell = cmd.finish && !matched && !ord_buy && !sell_full;

  always_comb begin
    buy_cmd         = '0;
    sell_cmd        = '0;
    buy_cmd.rotate  = cmd.step && !ord_buy && !hit;
    buy_cmd.drop    = cmd.step && !ord_buy && hit;
    buy_cmd.append  = app_buy;
    sell_cmd.rotate = cmd.step && ord_buy && !hit;
    sell_cmd.drop   = cmd.step && ord_buy && hit;
    sell_cmd.append = app_sell;
  end

  assign buy_after  = buy_cnt + CW'(app_buy);
  assign sell_after = sell_cnt + CW'(app_sell);
  assign buy_ext    = LW'(buy_after);
  assign sell_ext   = LW'(sell_after);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_id    <= order_id;
      ord_price <= order_price;
      ord_buy   <= is_buy;
    end
    if (cmd.step && hit) begin
      m_id    <= opp_id;
      m_price <= opp_price;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      matched   <= 1'b0;
    end else if (cmd.load) begin
      remaining <= is_buy ? sell_cnt : buy_cnt;
      matched   <= 1'b0;
    end else if (cmd.step) begin
      remaining <= remaining - CW'(1);
      if (hit) matched <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (matched) begin
        res_outcome <= OUT_TRADE;
        counter_id  <= m_id;
        trade_price <= m_price;
      end else begin
        res_outcome <= (app_buy || app_sell) ? OUT_ADDED : OUT_REJECT;
        counter_id  <= '0;
        trade_price <= '0;
      end
      buy_level  <= buy_ext[4:0];
      sell_level <= sell_ext[4:0];
    end
  end

  assign outcome = res_outcome;

endmodule
`default_nettype wire

[rtl/order_book_matcher_core.sv]
// Channel   Handshake        Payload
// request   start / busy     order_id[15:0] order_price[15:0] is_buy
// result    done (1 cycle)   outcome[1:0] counter_id[15:0] trade_price[15:0]
//                            buy_level[4:0] sell_level[4:0]
//
// A request is taken when start is high and busy is low.
// Each request scans all N entries of the opposite book, N being its size:
// the book is walked one entry a cycle from its head, rotating in place.
// done pulses in the first cycle with busy low; a new request may be taken then.
// rst is synchronous; both books come out of reset empty.
// The result side cannot stall.
`default_nettype none
module order_book_matcher_core #(
  parameter int BOOK_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] order_id,
  input  wire  [15:0] order_price,
  input  wire         is_buy,
  output logic        done,
  output logic [1:0]  outcome,
  output logic [15:0] counter_id,
  output logic [15:0] trade_price,
  output logic [4:0]  buy_level,
  output logic [4:0]  sell_level
);
  import obm_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  obm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  obm_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .order_id   (order_id),
    .order_price(order_price),
    .is_buy     (is_buy),
    .done       (done),
    .outcome    (outcome),
    .counter_id (counter_id),
    .trade_price(trade_price),
    .buy_level  (buy_level),
    .sell_level (sell_level)
  );

endmodule
`default_nettype wire

[rtl/obm_checker.sv]
`default_nettype none
module obm_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [1:0]  outcome,
  input wire [15:0] counter_id,
  input wire [15:0] trade_price
);
  import obm_pkg::*;

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome == OUT_ADDED || outcome == OUT_TRADE || outcome == OUT_REJECT))
    else $error("bad outcome code");

  a_no_trade_zero: assert property (@(posedge clk) disable iff (rst)
    (done && outcome != OUT_TRADE) |-> (counter_id == 16'd0 && trade_price == 16'd0))
    else $error("trade fields set without a trade");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but not busy");

  a_done_after: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("request finished without a result");

endmodule

bind order_book_matcher_core obm_checker u_chk (.*);
`default_nettype wire

[sim/order_book_matcher_core_test.sv]
`default_nettype none
module order_book_matcher_core_test;
  import obm_pkg::*;

  localparam int BOOK_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [15:0] id;
    logic [15:0] price;
  } resting_t;

  typedef struct {
    outcome_t    outcome;
    logic [15:0] counter_id;
    logic [15:0] trade_price;
    logic [4:0]  buy_level;
    logic [4:0]  sell_level;
  } fill_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] order_id;
  logic [15:0] order_price;
  logic        is_buy;
  logic        done;
  logic [1:0]  outcome;
  logic [15:0] counter_id;
  logic [15:0] trade_price;
  logic [4:0]  buy_level;
  logic [4:0]  sell_level;

  resting_t resting_buys[$];
  resting_t resting_sells[$];
  fill_t    pending_fills[$];
  int       mismatches = 0;
  int       max_gap = 5;
  int       idle_cycles = 0;

  order_book_matcher_core #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .order_id   (order_id),
    .order_price(order_price),
    .is_buy     (is_buy),
    .done       (done),
    .outcome    (outcome),
    .counter_id (counter_id),
    .trade_price(trade_price),
    .buy_level  (buy_level),
    .sell_level (sell_level)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Oldest qualifying entry on the opposite side wins; otherwise rest or reject.
  function automatic fill_t match_order(logic [15:0] id, logic [15:0] price, logic buy);
    fill_t    f;
    resting_t r;
    int       pos;
    int       i;
    f.outcome     = OUT_ADDED;
    f.counter_id  = '0;
    f.trade_price = '0;
    pos = -1;
    if (buy) begin
      for (i = 0; i < resting_sells.size(); i++) begin
        if (resting_sells[i].price <= price) begin
          pos = i;
          break;
        end
      end
    end else begin
      for (i = 0; i < resting_buys.size(); i++) begin
        if (resting_buys[i].price >= price) begin
          pos = i;
          break;
        end
      end
    end
    r.id    = id;
    r.price = price;
    if (pos >= 0) begin
      f.outcome = OUT_TRADE;
      if (buy) begin
        f.counter_id  = resting_sells[pos].id;
        f.trade_price = resting_sells[pos].price;
        resting_sells.delete(pos);
      end else begin
        f.counter_id  = resting_buys[pos].id;
        f.trade_price = resting_buys[pos].price;
        resting_buys.delete(pos);
      end
    end else if (buy && resting_buys.size() < BOOK_DEPTH) begin
      resting_buys.insert(resting_buys.size(), r);
    end else if (!buy && resting_sells.size() < BOOK_DEPTH) begin
      resting_sells.insert(resting_sells.size(), r);
    end else begin
      f.outcome = OUT_REJECT;
    end
    f.buy_level  = 5'(resting_buys.size());
    f.sell_level = 5'(resting_sells.size());
    return f;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    fill_t f;
    if (!rst && done) begin
      if (pending_fills.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        f = pending_fills.pop_front();
        check_field("outcome", {14'd0, outcome}, {14'd0, f.outcome});
        check_field("counter_id", counter_id, f.counter_id);
        check_field("trade_price", trade_price, f.trade_price);
        check_field("buy_level", {11'd0, buy_level}, {11'd0, f.buy_level});
        check_field("sell_level", {11'd0, sell_level}, {11'd0, f.sell_level});
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Leaves start high on return; the next call lowers it if it waits a gap first, and the drain lowers it.
  task automatic submit_order(logic [15:0] id, logic [15:0] price, logic buy);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    order_id    <= id;
    order_price <= price;
    is_buy      <= buy;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    pending_fills.insert(pending_fills.size(), match_order(id, price, buy));
  endtask

  task automatic wait_for_fills();
    @(negedge clk);
    start <= 1'b0;
    while (pending_fills.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    submit_order(16'h0000, 16'hFFFF, 1'b0);
    submit_order(16'hFFFF, 16'hFFFE, 1'b1);
    submit_order(16'h8000, 16'hFFFF, 1'b1);  // equal price crosses
    submit_order(16'h7FFF, 16'h0000, 1'b0);
    submit_order(16'h5555, 16'h0000, 1'b0);
    submit_order(16'hAAAA, 16'h0000, 1'b1);  // equal price at zero
  endtask

  task automatic test_oldest_wins();
    submit_order(16'd1, 16'd300, 1'b0);
    submit_order(16'd2, 16'd100, 1'b0);
    submit_order(16'd3, 16'd50, 1'b0);
    submit_order(16'd10, 16'd200, 1'b1);   // skips head, takes middle entry
    submit_order(16'd11, 16'd400, 1'b1);   // oldest beats better priced
  endtask

  task automatic test_book_full();
    int i;
    for (i = 0; i <= BOOK_DEPTH; i++)
      submit_order(16'h0100 + 16'(i), 16'd10, 1'b1);
    submit_order(16'h0200, 16'd5, 1'b0);
  endtask

  task automatic random_orders(int count, int buy_pct, int buy_lo, int buy_hi,
                               int sell_lo, int sell_hi);
    int          i;
    logic        buy;
    logic [15:0] price;
    for (i = 0; i < count; i++) begin
      buy = ($urandom_range(0, 99) < buy_pct);
      if ($urandom_range(0, 19) == 0)
        price = 16'($urandom());
      else if (buy)
        price = 16'($urandom_range(buy_lo, buy_hi));
      else
        price = 16'($urandom_range(sell_lo, sell_hi));
      submit_order(16'($urandom()), price, buy);
    end
  endtask

  task automatic test_random_balanced();
    random_orders(500, 50, 1000, 1063, 1000, 1063);
  endtask

  task automatic test_random_buy_pressure();
    max_gap = 0;
    random_orders(400, 75, 1000, 1063, 1000, 1063);
    max_gap = 5;
  endtask

  task automatic test_random_no_cross();
    random_orders(300, 50, 0, 127, 65408, 65535);
  endtask

  task automatic test_random_sweep();
    random_orders(150, 50, 65400, 65535, 0, 200);
  endtask

  task automatic test_random_sell_pressure();
    random_orders(400, 25, 1000, 1063, 1000, 1063);
  endtask

  task automatic test_random_tight_spread();
    max_gap = 1;
    random_orders(200, 50, 1000, 1003, 1000, 1003);
    max_gap = 5;
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    order_id    = '0;
    order_price = '0;
    is_buy      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_oldest_wins();
    test_book_full();
    test_random_balanced();
    test_random_buy_pressure();
    wait_for_fills();
    test_random_no_cross();
    test_random_sweep();
    wait_for_fills();
    test_random_sell_pressure();
    test_random_tight_spread();

    wait_for_fills();
    repeat (BOOK_DEPTH + 6) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
